### hw/rtl/mss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mss_pkg;

   localparam int unsigned WordWidth = 32;

   // What one cell shows to its neighbors.
   typedef struct packed {
      logic                        valid;
      logic                        take;
      logic signed [WordWidth-1:0] value;
   } cell_bus_type;

   // Operation applied to every cell of the row together.
   typedef struct packed {
      logic insert;
      logic drain;
   } row_ctl_type;

endpackage
`default_nettype wire

### hw/rtl/mss_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module mss_cell (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire mss_pkg::row_ctl_type                        ctl,
   input  wire logic signed [mss_pkg::WordWidth-1:0]        new_value,
   input  wire mss_pkg::cell_bus_type                       left,
   input  wire mss_pkg::cell_bus_type                       right,
   output mss_pkg::cell_bus_type                            self
);
   import mss_pkg::*;

   logic                        valid_ff;
   logic                        valid_in;
   logic signed [WordWidth-1:0] value_ff;
   logic signed [WordWidth-1:0] value_in;
   logic                        take;

   // An empty cell, or one holding a strictly larger value, gives way to the new value.
   assign take = !valid_ff || (value_ff > new_value);

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctl.drain) begin
         valid_in = right.valid;
         value_in = right.value;
      end else if (ctl.insert) begin
         valid_in = valid_ff | left.valid;
         if (left.take) begin
            value_in = left.value;
         end else if (take) begin
            value_in = new_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign self.valid = valid_ff;
   assign self.take  = take;
   assign self.value = value_ff;

endmodule
`default_nettype wire

### hw/rtl/merge_and_sort_sequences.sv
`timescale 1ns / 1ps
`default_nettype none
// Ascending insertion sorter built as a row of CAPACITY cells.
// Input channel (req_): one signed 32-bit value per transfer in req_tdata; req_tlast
// marks the last value of the set. Values of both sequences may come in any order.
// Output channel (rsp_): the stored values in ascending signed order in rsp_tdata,
// with equal values kept in arrival order. rsp_tlast marks the last value of the set
// and rsp_tuser is high on every value of a set in which values were dropped.
// Loading takes one value per cycle: every cell compares the new value in parallel
// and the row shifts right from the insertion point in the same cycle.
// When the store is full, further values are dropped and the overflow flag is set.
// After the last input transfer the block stops accepting input, and the first
// result is valid in the next cycle. Results then leave at one per cycle while
// rsp_tready is high, taken from the head cell while the row shifts left.
// A stall on rsp_tready simply holds the row and the result.
// After the last result the block is empty and accepts the next set.
// Reset (synchronous, active high) empties the row and clears the overflow flag;
// no clearing pass is needed since only occupied cells are ever read.
module merge_and_sort_sequences #(
   parameter int unsigned CAPACITY = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value
   input  wire logic        req_tlast,   // final_item
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] sorted_value
   output logic             rsp_tlast,   // final_result
   output logic             rsp_tuser    // [0] overflowed
);
   import mss_pkg::*;

   logic         draining_ff;
   logic         draining_in;
   logic         overflow_ff;
   logic         overflow_in;
   logic         req_xfer;
   logic         rsp_xfer;
   logic         full;
   row_ctl_type  ctl;
   cell_bus_type head_bus;
   cell_bus_type tail_bus;
   cell_bus_type cell_bus [CAPACITY];

   assign req_tready = !draining_ff;
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   assign full       = cell_bus[CAPACITY-1].valid;

   assign ctl.insert = req_xfer && !full;
   assign ctl.drain  = rsp_xfer;

   // The head never takes the new value and always counts as occupied, so the
   // first cell fills on any insert; the tail feeds empty cells during unload.
   assign head_bus.valid = 1'b1;
   assign head_bus.take  = 1'b0;
   assign head_bus.value = '0;
   assign tail_bus.valid = 1'b0;
   assign tail_bus.take  = 1'b0;
   assign tail_bus.value = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      cell_bus_type left_bus;
      cell_bus_type right_bus;
      if (i == 0) begin : g_head
         assign left_bus = head_bus;
      end else begin : g_mid
         assign left_bus = cell_bus[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign right_bus = tail_bus;
      end else begin : g_body
         assign right_bus = cell_bus[i+1];
      end
      mss_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .new_value (req_tdata),
         .left      (left_bus),
         .right     (right_bus),
         .self      (cell_bus[i])
      );
   end

   always_comb begin
      draining_in = draining_ff;
      overflow_in = overflow_ff;
      if (req_xfer) begin
         if (full) begin
            overflow_in = 1'b1;
         end
         if (req_tlast) begin
            draining_in = 1'b1;
         end
      end
      if (rsp_xfer && rsp_tlast) begin
         draining_in = 1'b0;
         overflow_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         draining_ff <= 1'b0;
         overflow_ff <= 1'b0;
      end else begin
         draining_ff <= draining_in;
         overflow_ff <= overflow_in;
      end
   end

   assign rsp_tvalid = draining_ff && cell_bus[0].valid;
   assign rsp_tdata  = cell_bus[0].value;
   assign rsp_tlast  = !cell_bus[1].valid;
   assign rsp_tuser  = overflow_ff;

endmodule
`default_nettype wire

### hw/rtl/mss_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module mss_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        req_tlast,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic        rsp_tlast,
   input wire logic        rsp_tuser
);

   // A result waiting on a stalled receiver stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // Input is refused while the sorted set is being unloaded.
   a_no_load_in_unload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input accepted during unload");

   // The last input of a set starts the unload in the next cycle.
   a_unload_starts: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> rsp_tvalid)
      else $error("unload did not start after last input");

   // Unload runs without gaps until the marked last result, then stops.
   a_unload_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && rsp_tuser == $past(rsp_tuser))
      else $error("unload broke off or overflow flag changed within a set");

   a_unload_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid && req_tready)
      else $error("results continued after the last one");

endmodule

bind merge_and_sort_sequences mss_checker u_mss_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
